FILE: hdl/orov_pkg.sv
package orov_pkg;

  // Default widths for the top-level parameters.
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned TRIG_FRAC_DEF  = 15;

  // Angles are in units of 1/64 degree.
  localparam int unsigned HALF_TURN_DEG = 180;
  localparam int unsigned ANG_W         = 15;
  localparam int unsigned R_W           = 13;
  localparam logic [ANG_W-1:0] ANG_QUARTER = ANG_W'(HALF_TURN_DEG * 64 / 2);
  localparam logic [ANG_W-1:0] ANG_HALF    = ANG_W'(HALF_TURN_DEG * 64);
  localparam logic [ANG_W-1:0] ANG_3Q      = ANG_W'(HALF_TURN_DEG * 64 * 3 / 2);
  localparam logic [ANG_W-1:0] ANG_FULL    = ANG_W'(HALF_TURN_DEG * 64 * 2);

  // Quadrant codes.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // The quarter turn is 128 * DIV_BASE, so t = r * 2^30 / quarter = r * 2^23 / DIV_BASE.
  // r is split as DIV_BASE * qq + rr, and rr * 2^23 / DIV_BASE as
  // rr * T_STEP + floor(rr * T_REM / DIV_BASE).
  localparam int unsigned DIV_BASE    = 45;
  localparam int unsigned QQ_W        = 8;
  localparam int unsigned RR_W        = 6;
  localparam int unsigned DIV45_MUL   = 11651;
  localparam int unsigned DIV45_SH    = 19;
  localparam int unsigned T_INT_SH    = 23;
  localparam int unsigned T_STEP      = 186413;
  localparam int unsigned T_FRAC_MUL  = 66999;
  localparam int unsigned T_FRAC_SH   = 17;

  // Horner word and Q30 Taylor coefficients of the sine.
  localparam int unsigned HQ_W = 31;
  localparam int unsigned Q_SH = 30;
  localparam logic [HQ_W-1:0] K1 = 31'd1686629713;
  localparam logic [HQ_W-1:0] K3 = 31'd693598669;
  localparam logic [HQ_W-1:0] K5 = 31'd85569306;
  localparam logic [HQ_W-1:0] K7 = 31'd5026996;
  localparam logic [HQ_W-1:0] K9 = 31'd172272;

  // Pipeline latencies in register stages.
  localparam int unsigned QS_LAT    = 9;
  localparam int unsigned TRIG_LAT  = QS_LAT + 2;
  localparam int unsigned EDGE_LAT  = 2;
  localparam int unsigned SAT_LAT   = 4;
  localparam int unsigned TOTAL_LAT = TRIG_LAT + EDGE_LAT + SAT_LAT;

  // Coefficient for each Horner step, highest order first.
  function automatic logic [HQ_W-1:0] horner_k(input logic [1:0] idx);
    logic [HQ_W-1:0] k;
    case (idx)
      2'd0:    k = K7;
      2'd1:    k = K5;
      2'd2:    k = K3;
      default: k = K1;
    endcase
    return k;
  endfunction

endpackage

FILE: hdl/orov_qsine.sv
module orov_qsine #(
  parameter int unsigned TRIG_FRAC_BITS = orov_pkg::TRIG_FRAC_DEF
) (
  input  logic                          clk_i,
  input  logic [orov_pkg::R_W-1:0]      x_i,
  output logic [TRIG_FRAC_BITS:0]       sin_o
);

  localparam int unsigned HW = orov_pkg::HQ_W;
  localparam int unsigned MW = 2 * HW;
  localparam int unsigned SW = TRIG_FRAC_BITS + 1;
  localparam logic [SW-1:0] ONE = {1'b1, {TRIG_FRAC_BITS{1'b0}}};

  // Stage 1: quotient by the base through a reciprocal multiply.
  logic [26:0] qmul;
  logic [orov_pkg::R_W-1:0] x1_q;
  logic [orov_pkg::QQ_W-1:0] qq1_q;
  assign qmul = 27'(x_i) * 27'(orov_pkg::DIV45_MUL);
  always_ff @(posedge clk_i) begin
    x1_q  <= x_i;
    qq1_q <= qmul[orov_pkg::DIV45_SH +: orov_pkg::QQ_W];
  end

  // Stage 2: remainder.
  logic [orov_pkg::R_W-1:0] rfull;
  logic [orov_pkg::QQ_W-1:0] qq2_q;
  logic [orov_pkg::RR_W-1:0] rr2_q;
  assign rfull = x1_q - orov_pkg::R_W'(qq1_q) * orov_pkg::R_W'(orov_pkg::DIV_BASE);
  always_ff @(posedge clk_i) begin
    qq2_q <= qq1_q;
    rr2_q <= rfull[orov_pkg::RR_W-1:0];
  end

  // Stage 3: scaled argument t in Q30.
  logic [22:0] fmul;
  logic [HW-1:0] t_d, t3_q;
  assign fmul = 23'(rr2_q) * 23'(orov_pkg::T_FRAC_MUL);
  assign t_d  = (HW'(qq2_q) << orov_pkg::T_INT_SH)
              + HW'(rr2_q) * HW'(orov_pkg::T_STEP)
              + HW'(fmul[22:orov_pkg::T_FRAC_SH]);
  always_ff @(posedge clk_i) begin
    t3_q <= t_d;
  end

  // Stage 4: t squared.
  logic [MW-1:0] tsq;
  logic [HW-1:0] t4_q, t2_q;
  assign tsq = MW'(t3_q) * MW'(t3_q);
  always_ff @(posedge clk_i) begin
    t4_q <= t3_q;
    t2_q <= tsq[orov_pkg::Q_SH +: HW];
  end

  // Stages 5 to 8: one Horner step each.
  logic [HW-1:0] hp_q [4];
  logic [HW-1:0] ht_q [4];
  logic [HW-1:0] ht2_q [3];

  for (genvar i = 0; i < 4; i++) begin : g_horner
    logic [HW-1:0] p_in, t_in, t2_in;
    logic [MW-1:0] m;
    if (i == 0) begin : g_first
      assign p_in  = orov_pkg::K9;
      assign t_in  = t4_q;
      assign t2_in = t2_q;
    end else begin : g_next
      assign p_in  = hp_q[i-1];
      assign t_in  = ht_q[i-1];
      assign t2_in = ht2_q[i-1];
    end
    assign m = MW'(t2_in) * MW'(p_in);
    always_ff @(posedge clk_i) begin
      hp_q[i] <= orov_pkg::horner_k(2'(i)) - m[orov_pkg::Q_SH +: HW];
      ht_q[i] <= t_in;
    end
    if (i < 3) begin : g_t2
      always_ff @(posedge clk_i) begin
        ht2_q[i] <= t2_in;
      end
    end
  end

  // Stage 9: final product, round to the trig scale and clamp at one.
  logic [MW-1:0] sm;
  logic [31:0] srnd, ssh;
  logic [SW-1:0] sin_d, sin_q;
  assign sm   = MW'(ht_q[3]) * MW'(hp_q[3]);
  assign srnd = 32'(sm[orov_pkg::Q_SH +: HW]) + (32'd1 << (29 - TRIG_FRAC_BITS));
  assign ssh  = srnd >> (30 - TRIG_FRAC_BITS);
  assign sin_d = (ssh > 32'(ONE)) ? ONE : ssh[SW-1:0];
  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
  end
  assign sin_o = sin_q;

endmodule

FILE: hdl/orov_trig.sv
module orov_trig #(
  parameter int unsigned TRIG_FRAC_BITS = orov_pkg::TRIG_FRAC_DEF
) (
  input  logic                              clk_i,
  input  logic [orov_pkg::ANG_W-1:0]        angle_i,
  output logic signed [TRIG_FRAC_BITS+1:0]  sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0]  cos_o
);

  localparam int unsigned SW = TRIG_FRAC_BITS + 1;
  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam logic [SW-1:0] ONE = {1'b1, {TRIG_FRAC_BITS{1'b0}}};
  localparam int unsigned DL = orov_pkg::QS_LAT;

  // Stage A: wrap the angle, split it into quadrant and remainder.
  logic [orov_pkg::ANG_W-1:0] awrap, abase, arem;
  logic [1:0] quad_d;
  always_comb begin
    awrap = (angle_i >= orov_pkg::ANG_FULL) ? angle_i - orov_pkg::ANG_FULL : angle_i;
    if (awrap >= orov_pkg::ANG_3Q) begin
      quad_d = orov_pkg::QUAD_3;
      abase  = orov_pkg::ANG_3Q;
    end else if (awrap >= orov_pkg::ANG_HALF) begin
      quad_d = orov_pkg::QUAD_2;
      abase  = orov_pkg::ANG_HALF;
    end else if (awrap >= orov_pkg::ANG_QUARTER) begin
      quad_d = orov_pkg::QUAD_1;
      abase  = orov_pkg::ANG_QUARTER;
    end else begin
      quad_d = orov_pkg::QUAD_0;
      abase  = '0;
    end
    arem = awrap - abase;
  end

  logic [1:0] quad_q;
  logic [orov_pkg::R_W-1:0] r_q, rc_q;
  logic zero_q;
  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    r_q    <= arem[orov_pkg::R_W-1:0];
    rc_q   <= orov_pkg::R_W'(orov_pkg::ANG_QUARTER) - arem[orov_pkg::R_W-1:0];
    zero_q <= (arem == '0);
  end

  // Sine of the remainder and of its complement.
  logic [SW-1:0] s0, c0raw;
  orov_qsine #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin (
    .clk_i (clk_i),
    .x_i   (r_q),
    .sin_o (s0)
  );
  orov_qsine #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos (
    .clk_i (clk_i),
    .x_i   (rc_q),
    .sin_o (c0raw)
  );

  // Quadrant and zero flag follow the sine pipeline.
  logic [1:0] quad_dly_q [DL];
  logic zero_dly_q [DL];
  always_ff @(posedge clk_i) begin
    quad_dly_q[0] <= quad_q;
    zero_dly_q[0] <= zero_q;
    for (int i = 1; i < DL; i++) begin
      quad_dly_q[i] <= quad_dly_q[i-1];
      zero_dly_q[i] <= zero_dly_q[i-1];
    end
  end

  // Stage B: exact cosine at zero, then swap and negate by quadrant.
  logic signed [TW-1:0] sp, cp, s_d, c_d, s_q, c_q;
  always_comb begin
    sp = signed'({1'b0, s0});
    cp = zero_dly_q[DL-1] ? signed'({1'b0, ONE}) : signed'({1'b0, c0raw});
    case (quad_dly_q[DL-1])
      orov_pkg::QUAD_0: begin
        s_d = sp;
        c_d = cp;
      end
      orov_pkg::QUAD_1: begin
        s_d = cp;
        c_d = -sp;
      end
      orov_pkg::QUAD_2: begin
        s_d = -sp;
        c_d = -cp;
      end
      default: begin
        s_d = -cp;
        c_d = sp;
      end
    endcase
  end
  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    c_q <= c_d;
  end
  assign sin_o = s_q;
  assign cos_o = c_q;

endmodule

FILE: hdl/orov_edge.sv
module orov_edge #(
  parameter int unsigned COORD_BITS     = orov_pkg::COORD_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = orov_pkg::TRIG_FRAC_DEF
) (
  input  logic                               clk_i,
  input  logic signed [COORD_BITS-1:0]       center_x_i,
  input  logic signed [COORD_BITS-1:0]       center_y_i,
  input  logic [COORD_BITS-1:0]              width_i,
  input  logic [COORD_BITS-1:0]              height_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]   sin_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]   cos_i,
  output logic signed [COORD_BITS:0]         cx2_o,
  output logic signed [COORD_BITS:0]         cy2_o,
  output logic signed [COORD_BITS+1:0]       ex_o,
  output logic signed [COORD_BITS+1:0]       ey_o,
  output logic signed [COORD_BITS+1:0]       fx_o,
  output logic signed [COORD_BITS+1:0]       fy_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   ux_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   uy_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   vx_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   vy_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned PW = CW + 1 + TW;
  localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (TRIG_FRAC_BITS - 1));
  localparam logic signed [TW-1:0] ONE = TW'(64'sd1 <<< TRIG_FRAC_BITS);

  // Round half up from the trig scale: floor(v / 2^frac + 1/2).
  function automatic logic signed [CW+1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] sh;
    sh = (v + HALF) >>> TRIG_FRAC_BITS;
    return sh[CW+1:0];
  endfunction

  // Stage 1: size times sine and cosine. The F vector uses -h*sin before rounding.
  logic signed [CW:0] wsg, hsg;
  logic signed [TW-1:0] nsin;
  logic signed [PW-1:0] pwc_q, pws_q, phs_q, phc_q;
  logic signed [CW:0] cx2_q, cy2_q;
  logic signed [TW-1:0] s_q, c_q;
  logic wz_q;
  assign wsg  = signed'({1'b0, width_i});
  assign hsg  = signed'({1'b0, height_i});
  assign nsin = -sin_i;
  always_ff @(posedge clk_i) begin
    pwc_q <= PW'(wsg) * PW'(cos_i);
    pws_q <= PW'(wsg) * PW'(sin_i);
    phs_q <= PW'(hsg) * PW'(nsin);
    phc_q <= PW'(hsg) * PW'(cos_i);
    cx2_q <= {center_x_i, 1'b0};
    cy2_q <= {center_y_i, 1'b0};
    s_q   <= sin_i;
    c_q   <= cos_i;
    wz_q  <= (width_i == '0);
  end

  // Stage 2: rounded edge vectors and the two axes of this rectangle (axis-aligned at zero width).
  logic signed [CW:0] cx2o_q, cy2o_q;
  logic signed [CW+1:0] ex_q, ey_q, fx_q, fy_q;
  logic signed [TW-1:0] ux_q, uy_q, vx_q, vy_q;
  always_ff @(posedge clk_i) begin
    cx2o_q <= cx2_q;
    cy2o_q <= cy2_q;
    ex_q   <= rnd(pwc_q);
    ey_q   <= rnd(pws_q);
    fx_q   <= rnd(phs_q);
    fy_q   <= rnd(phc_q);
    if (wz_q) begin
      ux_q <= ONE;
      uy_q <= '0;
      vx_q <= '0;
      vy_q <= ONE;
    end else begin
      ux_q <= c_q;
      uy_q <= s_q;
      vx_q <= -s_q;
      vy_q <= c_q;
    end
  end

  assign cx2_o = cx2o_q;
  assign cy2_o = cy2o_q;
  assign ex_o  = ex_q;
  assign ey_o  = ey_q;
  assign fx_o  = fx_q;
  assign fy_o  = fy_q;
  assign ux_o  = ux_q;
  assign uy_o  = uy_q;
  assign vx_o  = vx_q;
  assign vy_o  = vy_q;

endmodule

FILE: hdl/orov_sat.sv
module orov_sat #(
  parameter int unsigned COORD_BITS     = orov_pkg::COORD_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = orov_pkg::TRIG_FRAC_DEF
) (
  input  logic                              clk_i,
  input  logic signed [COORD_BITS:0]        a_cx2_i,
  input  logic signed [COORD_BITS:0]        a_cy2_i,
  input  logic signed [COORD_BITS+1:0]      a_ex_i,
  input  logic signed [COORD_BITS+1:0]      a_ey_i,
  input  logic signed [COORD_BITS+1:0]      a_fx_i,
  input  logic signed [COORD_BITS+1:0]      a_fy_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  a_ux_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  a_uy_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  a_vx_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  a_vy_i,
  input  logic signed [COORD_BITS:0]        b_cx2_i,
  input  logic signed [COORD_BITS:0]        b_cy2_i,
  input  logic signed [COORD_BITS+1:0]      b_ex_i,
  input  logic signed [COORD_BITS+1:0]      b_ey_i,
  input  logic signed [COORD_BITS+1:0]      b_fx_i,
  input  logic signed [COORD_BITS+1:0]      b_fy_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  b_ux_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  b_uy_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  b_vx_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  b_vy_i,
  output logic                              apart_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned MW = CW + TW + 2;
  localparam int unsigned SW = MW + 4;

  // Gather axes and rectangle terms into arrays.
  logic signed [TW-1:0] ax [4];
  logic signed [TW-1:0] ay [4];
  logic signed [CW:0] cx2 [2];
  logic signed [CW:0] cy2 [2];
  logic signed [CW+1:0] ex [2];
  logic signed [CW+1:0] ey [2];
  logic signed [CW+1:0] fx [2];
  logic signed [CW+1:0] fy [2];
  assign ax[0] = a_ux_i;
  assign ay[0] = a_uy_i;
  assign ax[1] = a_vx_i;
  assign ay[1] = a_vy_i;
  assign ax[2] = b_ux_i;
  assign ay[2] = b_uy_i;
  assign ax[3] = b_vx_i;
  assign ay[3] = b_vy_i;
  assign cx2[0] = a_cx2_i;
  assign cy2[0] = a_cy2_i;
  assign ex[0]  = a_ex_i;
  assign ey[0]  = a_ey_i;
  assign fx[0]  = a_fx_i;
  assign fy[0]  = a_fy_i;
  assign cx2[1] = b_cx2_i;
  assign cy2[1] = b_cy2_i;
  assign ex[1]  = b_ex_i;
  assign ey[1]  = b_ey_i;
  assign fx[1]  = b_fx_i;
  assign fy[1]  = b_fy_i;

  function automatic logic signed [SW-1:0] sabs(input logic signed [SW-1:0] v);
    return v[SW-1] ? -v : v;
  endfunction

  logic signed [MW-1:0] pcx_q [4][2];
  logic signed [MW-1:0] pcy_q [4][2];
  logic signed [MW-1:0] pex_q [4][2];
  logic signed [MW-1:0] pey_q [4][2];
  logic signed [MW-1:0] pfx_q [4][2];
  logic signed [MW-1:0] pfy_q [4][2];
  logic signed [SW-1:0] diff_q [4];
  logic signed [SW-1:0] pe_q [4][2];
  logic signed [SW-1:0] pf_q [4][2];
  logic signed [SW-1:0] adiff_q [4];
  logic signed [SW-1:0] rad_q [4];
  logic [3:0] sep;
  logic apart_q;

  for (genvar k = 0; k < 4; k++) begin : g_axis
    // Stage 1: every term projected onto this axis.
    for (genvar r = 0; r < 2; r++) begin : g_rect
      always_ff @(posedge clk_i) begin
        pcx_q[k][r] <= MW'(cx2[r]) * MW'(ax[k]);
        pcy_q[k][r] <= MW'(cy2[r]) * MW'(ay[k]);
        pex_q[k][r] <= MW'(ex[r]) * MW'(ax[k]);
        pey_q[k][r] <= MW'(ey[r]) * MW'(ay[k]);
        pfx_q[k][r] <= MW'(fx[r]) * MW'(ax[k]);
        pfy_q[k][r] <= MW'(fy[r]) * MW'(ay[k]);
      end
      // Stage 2: edge projections.
      always_ff @(posedge clk_i) begin
        pe_q[k][r] <= SW'(pex_q[k][r]) + SW'(pey_q[k][r]);
        pf_q[k][r] <= SW'(pfx_q[k][r]) + SW'(pfy_q[k][r]);
      end
    end

    // Stage 2: signed difference of the projected centers.
    always_ff @(posedge clk_i) begin
      diff_q[k] <= SW'(pcx_q[k][0]) + SW'(pcy_q[k][0])
                 - SW'(pcx_q[k][1]) - SW'(pcy_q[k][1]);
    end

    // Stage 3: magnitudes and the summed half extents.
    always_ff @(posedge clk_i) begin
      adiff_q[k] <= sabs(diff_q[k]);
      rad_q[k]   <= sabs(pe_q[k][0]) + sabs(pf_q[k][0])
                  + sabs(pe_q[k][1]) + sabs(pf_q[k][1]);
    end

    // Strictly disjoint intervals separate; touching does not.
    assign sep[k] = adiff_q[k] > rad_q[k];
  end

  // Stage 4: any separating axis.
  always_ff @(posedge clk_i) begin
    apart_q <= |sep;
  end
  assign apart_o = apart_q;

endmodule

FILE: hdl/oriented_rectangle_overlap.sv
// Oriented rectangle overlap test.
// Each input beat carries two rectangles (center, width, height, rotation in
// 1/64 degree) and is taken at a rising edge where start_i is high and busy_o
// is low. busy_o is always low: a new pair may be presented in every cycle.
// Each pair yields one result beat: done_o is high for exactly one cycle and
// apart_o is 1 when some edge axis separates the rectangles, 0 when they
// overlap or touch. Results leave in input order.
// Throughput is one pair per cycle. Each pair passes through the
// eleven-stage sine and cosine path (angle split, nine stages of reciprocal
// split and Horner multiplies, quadrant swap), followed by two stages of
// edge-vector products and four stages of projection, magnitude and compare.
// The receiver cannot hold results off, so no stall exists on either side.
// Reset clears the valid pipeline; pairs in flight are dropped and no result
// beat appears until a new pair is accepted.
module oriented_rectangle_overlap #(
  parameter int unsigned COORD_BITS     = orov_pkg::COORD_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = orov_pkg::TRIG_FRAC_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [COORD_BITS-1:0]      a_center_x_i,
  input  logic signed [COORD_BITS-1:0]      a_center_y_i,
  input  logic [COORD_BITS-1:0]             a_width_i,
  input  logic [COORD_BITS-1:0]             a_height_i,
  input  logic [orov_pkg::ANG_W-1:0]        a_angle_i,
  input  logic signed [COORD_BITS-1:0]      b_center_x_i,
  input  logic signed [COORD_BITS-1:0]      b_center_y_i,
  input  logic [COORD_BITS-1:0]             b_width_i,
  input  logic [COORD_BITS-1:0]             b_height_i,
  input  logic [orov_pkg::ANG_W-1:0]        b_angle_i,
  output logic                              done_o,
  output logic                              apart_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned DW = 4 * CW;
  localparam int unsigned TL = orov_pkg::TRIG_LAT;
  localparam int unsigned NL = orov_pkg::TOTAL_LAT;
  localparam logic signed [TW-1:0] ONE = TW'(64'sd1 <<< TRIG_FRAC_BITS);

  assign busy_o = 1'b0;

  // Valid bits travel beside the data pipeline.
  logic [NL-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NL-2:0], start_i & ~busy_o};
    end
  end
  assign done_o = vld_q[NL-1];

  // Sizes and centers wait for the sine and cosine.
  logic [DW-1:0] a_dly_q [TL];
  logic [DW-1:0] b_dly_q [TL];
  always_ff @(posedge clk_i) begin
    a_dly_q[0] <= {a_center_x_i, a_center_y_i, a_width_i, a_height_i};
    b_dly_q[0] <= {b_center_x_i, b_center_y_i, b_width_i, b_height_i};
    for (int i = 1; i < TL; i++) begin
      a_dly_q[i] <= a_dly_q[i-1];
      b_dly_q[i] <= b_dly_q[i-1];
    end
  end

  logic signed [CW-1:0] a_cx_d, a_cy_d, b_cx_d, b_cy_d;
  logic [CW-1:0] a_w_d, a_h_d, b_w_d, b_h_d;
  assign {a_cx_d, a_cy_d, a_w_d, a_h_d} = a_dly_q[TL-1];
  assign {b_cx_d, b_cy_d, b_w_d, b_h_d} = b_dly_q[TL-1];

  // Sine and cosine of both angles.
  logic signed [TW-1:0] a_sin, a_cos, b_sin, b_cos;
  orov_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_a (
    .clk_i   (clk_i),
    .angle_i (a_angle_i),
    .sin_o   (a_sin),
    .cos_o   (a_cos)
  );
  orov_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_b (
    .clk_i   (clk_i),
    .angle_i (b_angle_i),
    .sin_o   (b_sin),
    .cos_o   (b_cos)
  );

  // Edge vectors and axes of each rectangle.
  logic signed [CW:0] a_cx2, a_cy2, b_cx2, b_cy2;
  logic signed [CW+1:0] a_ex, a_ey, a_fx, a_fy, b_ex, b_ey, b_fx, b_fy;
  logic signed [TW-1:0] a_ux, a_uy, a_vx, a_vy, b_ux, b_uy, b_vx, b_vy;

  orov_edge #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_edge_a (
    .clk_i      (clk_i),
    .center_x_i (a_cx_d),
    .center_y_i (a_cy_d),
    .width_i    (a_w_d),
    .height_i   (a_h_d),
    .sin_i      (a_sin),
    .cos_i      (a_cos),
    .cx2_o      (a_cx2),
    .cy2_o      (a_cy2),
    .ex_o       (a_ex),
    .ey_o       (a_ey),
    .fx_o       (a_fx),
    .fy_o       (a_fy),
    .ux_o       (a_ux),
    .uy_o       (a_uy),
    .vx_o       (a_vx),
    .vy_o       (a_vy)
  );
  orov_edge #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_edge_b (
    .clk_i      (clk_i),
    .center_x_i (b_cx_d),
    .center_y_i (b_cy_d),
    .width_i    (b_w_d),
    .height_i   (b_h_d),
    .sin_i      (b_sin),
    .cos_i      (b_cos),
    .cx2_o      (b_cx2),
    .cy2_o      (b_cy2),
    .ex_o       (b_ex),
    .ey_o       (b_ey),
    .fx_o       (b_fx),
    .fy_o       (b_fy),
    .ux_o       (b_ux),
    .uy_o       (b_uy),
    .vx_o       (b_vx),
    .vy_o       (b_vy)
  );

  // Separating axis test over the U and V axes of both rectangles.
  orov_sat #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sat (
    .clk_i   (clk_i),
    .a_cx2_i (a_cx2),
    .a_cy2_i (a_cy2),
    .a_ex_i  (a_ex),
    .a_ey_i  (a_ey),
    .a_fx_i  (a_fx),
    .a_fy_i  (a_fy),
    .a_ux_i  (a_ux),
    .a_uy_i  (a_uy),
    .a_vx_i  (a_vx),
    .a_vy_i  (a_vy),
    .b_cx2_i (b_cx2),
    .b_cy2_i (b_cy2),
    .b_ex_i  (b_ex),
    .b_ey_i  (b_ey),
    .b_fx_i  (b_fx),
    .b_fy_i  (b_fy),
    .b_ux_i  (b_ux),
    .b_uy_i  (b_uy),
    .b_vx_i  (b_vx),
    .b_vy_i  (b_vy),
    .apart_o (apart_o)
  );

  // A result beat always goes back to an accepted pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, orov_pkg::TOTAL_LAT))
    else $error("result beat without a matching input beat");

  // Sine and cosine of a live pair stay within one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[TL-1] |-> (a_sin <= ONE && a_sin >= -ONE && a_cos <= ONE && a_cos >= -ONE))
    else $error("trig value beyond unity");

  // A zero-width rectangle A has a null E vector and a U axis along x.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[TL-1] && a_w_d == '0) |-> ##2
      (a_ex == '0 && a_ey == '0 && a_ux == ONE && a_uy == '0))
    else $error("zero-width rectangle not reduced to axis-aligned axes");

endmodule
